FILE: rtl/gbts_pkg.sv
// ----------------------------------------------------------------------------
// gbts_pkg
// Shared sizes, codes and types of the gap buffer text store.
// ----------------------------------------------------------------------------
package gbts_pkg;

  // Store geometry
  localparam int CAPACITY = 4096;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int LEN_W    = 13;
  localparam int BYTE_W   = 8;
  localparam int OP_W     = 2;
  localparam int STAT_W   = 2;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [BYTE_W-1:0] byte_t;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_FIND   = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_RANGE     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

endpackage

FILE: rtl/gbts_if.sv
// ----------------------------------------------------------------------------
// gbts_if
// Valid/ready channels of the gap buffer text store: command in, result out.
// ----------------------------------------------------------------------------
interface gbts_in_if;
  logic                        valid;
  logic                        ready;
  logic [gbts_pkg::OP_W-1:0]   op;
  logic [gbts_pkg::LEN_W-1:0]  position;
  logic [gbts_pkg::BYTE_W-1:0] char_value;

  modport source (output valid, output op, output position, output char_value,
                  input ready);
  modport sink   (input valid, input op, input position, input char_value,
                  output ready);
endinterface

interface gbts_out_if;
  logic                        valid;
  logic                        ready;
  logic [gbts_pkg::STAT_W-1:0] status;
  logic [gbts_pkg::LEN_W-1:0]  found_index;
  logic [gbts_pkg::BYTE_W-1:0] read_byte;
  logic [gbts_pkg::LEN_W-1:0]  text_length;

  modport source (output valid, output status, output found_index,
                  output read_byte, output text_length, input ready);
  modport sink   (input valid, input status, input found_index,
                  input read_byte, input text_length, output ready);
endinterface

FILE: rtl/gbts_store.sv
// ----------------------------------------------------------------------------
// gbts_store
// Byte store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gbts_store (
  input  logic            clk,
  input  logic            wr_en,
  input  gbts_pkg::addr_t wr_addr,
  input  gbts_pkg::byte_t wr_data,
  input  logic            rd_en,
  input  gbts_pkg::addr_t rd_addr,
  output gbts_pkg::byte_t rd_data
);

  gbts_pkg::byte_t mem [gbts_pkg::CAPACITY];

  // Write a byte
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Register the read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/gap_buffer_text_store_core.sv
// ----------------------------------------------------------------------------
// gap_buffer_text_store_core
// Gap buffer over a byte store: insert, delete, find and read commands.
// ----------------------------------------------------------------------------
//
//  channel | dir | beat contents
//  --------+-----+---------------------------------------------------
//  in_ch   | in  | op, position, char_value
//  out_ch  | out | status, found_index, read_byte, text_length
//
//  Insert and delete decode, step the gap byte by byte toward the target and
//  finish the edit; find decodes, then reads and compares byte by byte until
//  a match or the end of text; read decodes and waits for the read data; a
//  command rejected in decode (full buffer, position out of range) goes
//  straight to the result. Each gap step and each scan step is one read of
//  the store followed by a write or a compare. Reset sets the state, the gap
//  pointers and the output valid flag only; the store has no clearing pass
//  and its bytes are undefined until written. in_ch.ready is high only while
//  the sequencer is idle; a finished result waits in the output register
//  while the next command is taken, and a held result stalls the sequencer.
//
module gap_buffer_text_store_core (
  input  logic       clk,
  input  logic       rst_n,
  gbts_in_if.sink    in_ch,
  gbts_out_if.source out_ch
);

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_DECODE    = 8'b0000_0010,
    S_MOVE      = 8'b0000_0100,
    S_MOVE_WR   = 8'b0000_1000,
    S_FIND_RD   = 8'b0001_0000,
    S_FIND_CMP  = 8'b0010_0000,
    S_READ_WAIT = 8'b0100_0000,
    S_RESP      = 8'b1000_0000
  } state_t;

  localparam gbts_pkg::len_t CAP_LEN = gbts_pkg::LEN_W'(gbts_pkg::CAPACITY);

  state_t           state_r, state_nxt;
  gbts_pkg::len_t   gap_start_r, gap_start_nxt;
  gbts_pkg::len_t   gap_stop_r, gap_stop_nxt;
  gbts_pkg::op_t    op_r, op_nxt;
  gbts_pkg::len_t   pos_r, pos_nxt;
  gbts_pkg::byte_t  char_r, char_nxt;
  gbts_pkg::len_t   target_r, target_nxt;
  gbts_pkg::len_t   idx_r, idx_nxt;
  logic             left_r, left_nxt;
  gbts_pkg::status_t res_status_r, res_status_nxt;
  gbts_pkg::len_t   res_found_r, res_found_nxt;
  gbts_pkg::byte_t  res_byte_r, res_byte_nxt;

  logic             out_valid_r, out_valid_nxt;
  gbts_pkg::status_t out_status_r, out_status_nxt;
  gbts_pkg::len_t   out_found_r, out_found_nxt;
  gbts_pkg::byte_t  out_byte_r, out_byte_nxt;
  gbts_pkg::len_t   out_len_r, out_len_nxt;

  logic             wr_en;
  gbts_pkg::addr_t  wr_addr;
  gbts_pkg::byte_t  wr_data;
  logic             rd_en;
  gbts_pkg::addr_t  rd_addr;
  gbts_pkg::byte_t  rd_data;

  gbts_pkg::len_t   text_len;
  gbts_pkg::len_t   gap_width;
  gbts_pkg::len_t   phys_src;
  gbts_pkg::len_t   phys_idx;
  logic             in_accept;
  logic             out_take;

  // Text length and logical-to-physical mapping
  assign text_len  = gap_start_r + (CAP_LEN - gap_stop_r);
  assign gap_width = gap_stop_r - gap_start_r;
  assign phys_src  = (state_r == S_DECODE) ? pos_r : idx_r;
  assign phys_idx  = (phys_src < gap_start_r) ? phys_src : phys_src + gap_width;

  assign in_accept = in_ch.valid && in_ch.ready;
  assign out_take  = out_valid_r && out_ch.ready;

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.found_index = out_found_r;
  assign out_ch.read_byte   = out_byte_r;
  assign out_ch.text_length = out_len_r;

  gbts_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Sequence one command
  always_comb begin
    state_nxt      = state_r;
    gap_start_nxt  = gap_start_r;
    gap_stop_nxt   = gap_stop_r;
    op_nxt         = op_r;
    pos_nxt        = pos_r;
    char_nxt       = char_r;
    target_nxt     = target_r;
    idx_nxt        = idx_r;
    left_nxt       = left_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    res_byte_nxt   = res_byte_r;
    out_valid_nxt  = out_valid_r && !out_take;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_byte_nxt   = out_byte_r;
    out_len_nxt    = out_len_r;
    wr_en          = 1'b0;
    wr_addr        = gap_start_r[gbts_pkg::ADDR_W-1:0];
    wr_data        = char_r;
    rd_en          = 1'b0;
    rd_addr        = phys_idx[gbts_pkg::ADDR_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          op_nxt    = gbts_pkg::op_t'(in_ch.op);
          pos_nxt   = in_ch.position;
          char_nxt  = in_ch.char_value;
          state_nxt = S_DECODE;
        end
      end

      // Check range and pick the path
      S_DECODE: begin
        res_status_nxt = gbts_pkg::ST_OK;
        res_found_nxt  = '0;
        res_byte_nxt   = '0;
        unique case (op_r)
          gbts_pkg::OP_INSERT: begin
            if (gap_start_r == gap_stop_r) begin
              res_status_nxt = gbts_pkg::ST_FULL;
              state_nxt      = S_RESP;
            end else begin
              target_nxt = (pos_r > text_len) ? text_len : pos_r;
              state_nxt  = S_MOVE;
            end
          end
          gbts_pkg::OP_DELETE: begin
            if (pos_r >= text_len) begin
              res_status_nxt = gbts_pkg::ST_RANGE;
              state_nxt      = S_RESP;
            end else begin
              target_nxt = pos_r + 1'b1;
              state_nxt  = S_MOVE;
            end
          end
          gbts_pkg::OP_FIND: begin
            if (pos_r > text_len) begin
              res_status_nxt = gbts_pkg::ST_RANGE;
              state_nxt      = S_RESP;
            end else begin
              res_status_nxt = gbts_pkg::ST_NOT_FOUND;
              idx_nxt        = pos_r;
              state_nxt      = S_FIND_RD;
            end
          end
          gbts_pkg::OP_READ: begin
            if (pos_r >= text_len) begin
              res_status_nxt = gbts_pkg::ST_RANGE;
              state_nxt      = S_RESP;
            end else begin
              rd_en     = 1'b1;
              state_nxt = S_READ_WAIT;
            end
          end
          default: state_nxt = S_RESP;
        endcase
      end

      // Step the gap one byte toward the target, or finish the edit
      S_MOVE: begin
        if (gap_start_r < target_r && gap_stop_r < CAP_LEN) begin
          rd_en     = 1'b1;
          rd_addr   = gap_stop_r[gbts_pkg::ADDR_W-1:0];
          left_nxt  = 1'b0;
          state_nxt = S_MOVE_WR;
        end else if (gap_start_r > target_r && gap_start_r != '0) begin
          rd_en     = 1'b1;
          rd_addr   = gbts_pkg::ADDR_W'(gap_start_r - 1'b1);
          left_nxt  = 1'b1;
          state_nxt = S_MOVE_WR;
        end else begin
          if (op_r == gbts_pkg::OP_INSERT) begin
            wr_en         = 1'b1;
            gap_start_nxt = gap_start_r + 1'b1;
          end else begin
            gap_start_nxt = gap_start_r - 1'b1;
          end
          state_nxt = S_RESP;
        end
      end

      // Copy the byte across the gap
      S_MOVE_WR: begin
        wr_en   = 1'b1;
        wr_data = rd_data;
        if (left_r) begin
          wr_addr       = gbts_pkg::ADDR_W'(gap_stop_r - 1'b1);
          gap_start_nxt = gap_start_r - 1'b1;
          gap_stop_nxt  = gap_stop_r - 1'b1;
        end else begin
          wr_addr       = gap_start_r[gbts_pkg::ADDR_W-1:0];
          gap_start_nxt = gap_start_r + 1'b1;
          gap_stop_nxt  = gap_stop_r + 1'b1;
        end
        state_nxt = S_MOVE;
      end

      // Fetch the next candidate byte, or stop at the end of text
      S_FIND_RD: begin
        if (idx_r >= text_len) begin
          state_nxt = S_RESP;
        end else begin
          rd_en     = 1'b1;
          state_nxt = S_FIND_CMP;
        end
      end

      S_FIND_CMP: begin
        if (rd_data == char_r) begin
          res_status_nxt = gbts_pkg::ST_OK;
          res_found_nxt  = idx_r;
          state_nxt      = S_RESP;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_FIND_RD;
        end
      end

      S_READ_WAIT: begin
        res_byte_nxt = rd_data;
        state_nxt    = S_RESP;
      end

      // Hand the result to the output register once it is free
      S_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_found_nxt  = res_found_r;
          out_byte_nxt   = res_byte_r;
          out_len_nxt    = text_len;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gap_start_r <= '0;
      gap_stop_r  <= CAP_LEN;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gap_start_r <= gap_start_nxt;
      gap_stop_r  <= gap_stop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    pos_r        <= pos_nxt;
    char_r       <= char_nxt;
    target_r     <= target_nxt;
    idx_r        <= idx_nxt;
    left_r       <= left_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    res_byte_r   <= res_byte_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_byte_r   <= out_byte_nxt;
    out_len_r    <= out_len_nxt;
  end

`ifndef SYNTHESIS
  a_gap_order: assert property (@(posedge clk) disable iff (!rst_n)
    gap_start_r <= gap_stop_r)
    else $error("gap start passed gap stop");

  a_gap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    gap_stop_r <= CAP_LEN)
    else $error("gap stop beyond capacity");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> !in_ch.ready)
    else $error("command taken while previous one still in work");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_RESP) |-> !wr_en)
    else $error("store written outside an edit");
`endif

endmodule
